@@ src/icdf_pkg.sv @@
package icdf_pkg;

  typedef struct packed {
    logic        action;
    logic [9:0]  entry_index;
    logic [16:0] cdf_value;
    logic [15:0] level_index;
  } icdf_in_t;

  typedef struct packed {
    logic [15:0]        level_echo;
    logic signed [31:0] mapped_value;
  } icdf_out_t;

  // input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd3;

  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [31:0] START_RESET  = 32'd0;
  localparam logic [31:0] STEP_RESET   = 32'd65536;
  localparam logic [16:0] LEVELS_RESET = 17'd256;
  localparam logic [10:0] LENGTH_RESET = 11'd1024;

  localparam int DIV_STEPS = 16;

endpackage

@@ src/inverse_cdf_transform.sv @@
// Inverse distribution lookup with linear interpolation.
// Input channel: in_data is taken at a rising edge where start is high and busy is low.
// A load transaction (action 0) with entry_index below TABLE_DEPTH writes one cdf table entry
// in that same edge and leaves busy low, so loads may follow each other every cycle; it gives
// no result. A query transaction (action 1) raises busy and gives exactly one result.
// Result channel: out_valid is high for one cycle with out_data; the receiver
// cannot stall, so the block never waits on it. busy falls in the result cycle.
// Query: the table is walked from entry 0 through one read port of the
// table memory, one entry per cycle, until j, the first entry reaching the
// target, is found or the last entry in use is passed. When j is above 0, the
// read and multiply pipeline of the walk is followed by a 16-step restoring
// divider for the interpolation fraction; two arithmetic stages come last.
// Configuration: cfg_we/cfg_addr/cfg_data write one register per edge; the
// user must write only while the block is idle, which it does not enforce.
// Reset (rst_n low, synchronous) restores the register defaults and idles the
// block; table contents are kept and are undefined until written.
module inverse_cdf_transform #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  icdf_pkg::icdf_in_t                  in_data,
  output logic                                out_valid,
  output icdf_pkg::icdf_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [icdf_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [icdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import icdf_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W = IDX_W + 1;
  localparam int CMP_W = (LEN_W > 12) ? LEN_W : 12;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DEN, S_DIV, S_MUL, S_SUM
  } state_t;

  state_t state_r;

  logic [31:0] cfg_start_r;
  logic [31:0] cfg_step_r;
  logic [16:0] cfg_levels_r;
  logic [10:0] cfg_length_r;

  logic [16:0] cdf_mem [TABLE_DEPTH];
  logic [16:0] rd_data_r;

  // walk pipeline: issue, read data, product
  logic [IDX_W-1:0] a_r;
  logic             a_v_r;
  logic [IDX_W-1:0] b_idx_r;
  logic             b_v_r;
  logic [IDX_W-1:0] c_idx_r;
  logic             c_v_r;
  logic [16:0]      c_val_r;
  logic [33:0]      prod_r;
  logic [16:0]      prev_r;

  logic [IDX_W-1:0] last_r;
  logic [15:0]      lvl_r;
  logic [31:0]      tgt_r;
  logic [IDX_W-1:0] j_r;
  logic [33:0]      num_r;
  logic [16:0]      diff_r;
  logic [33:0]      den_r;
  logic [33:0]      rem_r;
  logic [15:0]      quot_r;
  logic [3:0]       cnt_r;
  logic [31:0]      jstep_r;
  logic [47:0]      dstep_r;

  logic            out_valid_r;
  icdf_out_t       out_data_r;

  logic             accept;
  logic             load_we;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_sat;
  logic [IDX_W-1:0] last_nxt;
  logic             hit;
  logic [34:0]      rem2;
  logic             rem_ge;
  logic [31:0]      jstep_nxt;
  logic signed [48:0] dstep_nxt;
  logic [47:0]      acc_nxt;

  assign accept  = start && !busy;
  assign load_we = accept && (in_data.action == ACT_LOAD) &&
                   (32'(in_data.entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    len_ext = CMP_W'(cfg_length_r);
    if (len_ext == '0) begin
      len_sat = CMP_W'(1);
    end else if (len_ext > CMP_W'(TABLE_DEPTH)) begin
      len_sat = CMP_W'(TABLE_DEPTH);
    end else begin
      len_sat = len_ext;
    end
    last_nxt = IDX_W'(len_sat - CMP_W'(1));
  end

  assign hit       = prod_r >= 34'(tgt_r);
  assign rem2      = {rem_r, 1'b0};
  assign rem_ge    = rem2 >= {1'b0, den_r};
  assign jstep_nxt = 32'(j_r) * cfg_step_r;
  assign dstep_nxt = 49'($signed(cfg_step_r)) * 49'($signed({1'b0, quot_r}));
  assign acc_nxt   = {cfg_start_r, 16'h0000} + {jstep_r, 16'h0000} - dstep_r
                     + 48'd32768;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r  <= START_RESET;
      cfg_step_r   <= STEP_RESET;
      cfg_levels_r <= LEVELS_RESET;
      cfg_length_r <= LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START:  cfg_start_r  <= cfg_data;
        CFG_STEP:   cfg_step_r   <= cfg_data;
        CFG_LEVELS: cfg_levels_r <= cfg_data[16:0];
        CFG_LENGTH: cfg_length_r <= cfg_data[10:0];
        default:    ;
      endcase
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (load_we) begin
      cdf_mem[IDX_W'(in_data.entry_index)] <= in_data.cdf_value;
    end
    rd_data_r <= cdf_mem[a_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.action == ACT_QUERY)) begin
            lvl_r   <= in_data.level_index;
            tgt_r   <= {in_data.level_index, 16'h0000};
            last_r  <= last_nxt;
            a_r     <= '0;
            a_v_r   <= 1'b1;
            b_v_r   <= 1'b0;
            c_v_r   <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          b_v_r   <= a_v_r;
          b_idx_r <= a_r;
          if (a_v_r) begin
            if (a_r == last_r) begin
              a_v_r <= 1'b0;
            end else begin
              a_r <= a_r + 1'b1;
            end
          end
          c_v_r   <= b_v_r;
          c_idx_r <= b_idx_r;
          c_val_r <= rd_data_r;
          prod_r  <= 34'(rd_data_r) * 34'(cfg_levels_r);
          if (c_v_r) begin
            if (hit) begin
              j_r     <= c_idx_r;
              num_r   <= prod_r - 34'(tgt_r);
              diff_r  <= c_val_r - prev_r;
              quot_r  <= '0;
              a_v_r   <= 1'b0;
              b_v_r   <= 1'b0;
              c_v_r   <= 1'b0;
              state_r <= (c_idx_r == '0) ? S_MUL : S_DEN;
            end else begin
              prev_r <= c_val_r;
              if (c_idx_r == last_r) begin
                // nothing reaches the target: last entry, no interpolation
                j_r     <= last_r;
                quot_r  <= '0;
                a_v_r   <= 1'b0;
                b_v_r   <= 1'b0;
                c_v_r   <= 1'b0;
                state_r <= S_MUL;
              end
            end
          end
        end
        S_DEN: begin
          den_r   <= 34'(cfg_levels_r) * 34'(diff_r);
          rem_r   <= num_r;
          cnt_r   <= 4'(DIV_STEPS - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // numerator below denominator, so 16 quotient bits suffice
          if (rem_ge) begin
            rem_r <= 34'(rem2 - {1'b0, den_r});
          end else begin
            rem_r <= rem2[33:0];
          end
          quot_r <= {quot_r[14:0], rem_ge};
          if (cnt_r == '0) begin
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MUL: begin
          jstep_r <= jstep_nxt;
          dstep_r <= dstep_nxt[47:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          out_data_r.level_echo   <= lvl_r;
          out_data_r.mapped_value <= acc_nxt[47:16];
          out_valid_r             <= 1'b1;
          state_r                 <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a query is still in progress");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_QUERY) |=> (busy && !out_valid))
    else $error("query transaction did not start a walk");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_LOAD) |=> (!busy && !out_valid))
    else $error("load transaction disturbed the idle state");

endmodule
